// File: sv/lzc_pkg.sv
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared types and constants for the greedy LZ77 compressor core.
// ----------------------------------------------------------------------------
package lzc_pkg;

    localparam int DEF_HISTORY_DEPTH   = 4096;
    localparam int DEF_LOOKAHEAD_DEPTH = 256;

    localparam int WIN_W  = 13;
    localparam int BYTE_W = 8;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 13'd4096;
    localparam logic [BYTE_W-1:0] MAXLEN_RESET = 8'hFF;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MAXLEN = 1'b1;
    localparam int   PADDR_W    = 3;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } lzc_op_e;

    // classified command handed from front to engine
    typedef struct packed {
        lzc_op_e             op;
        logic [BYTE_W-1:0]   data;
    } lzc_cmd_t;

    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [BYTE_W-1:0] max_match;
    } lzc_cfg_t;

endpackage

// File: sv/lzc_if.sv
// ----------------------------------------------------------------------------
// lzc_in_if / lzc_out_if
// Valid/ready channels for input items and output triples.
// ----------------------------------------------------------------------------
interface lzc_in_if import lzc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface lzc_out_if import lzc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WIN_W-1:0]  match_offset;
    logic [BYTE_W-1:0] match_length;
    logic [BYTE_W-1:0] literal;
    logic              last;

    modport source (output valid, output match_offset, output match_length,
                    output literal, output last, input ready);
    modport sink   (input valid, input match_offset, input match_length,
                    input literal, input last, output ready);
endinterface

// File: sv/lz77_greedy_compressor_core.sv
// ----------------------------------------------------------------------------
// lz77_greedy_compressor_core
// Greedy LZ77 encoder: byte/drain commands in, (offset, length, literal) out.
// ----------------------------------------------------------------------------
// Search: a push that emits nothing only passes the check state in the engine; a
//   triple takes a greedy search of compare steps, bounded by min(window, history)
//   * min(max_match, lookahead bytes - 1), then a copy of length+1 bytes to history.
// Throughput: one item at a time in the engine; a 2-entry queue and an output
//   register let input and output stall independently.
// Reset: asynchronous, active low; clears the buffers and loads default config.
module lz77_greedy_compressor_core import lzc_pkg::*;
#(
    parameter int HISTORY_DEPTH   = DEF_HISTORY_DEPTH,
    parameter int LOOKAHEAD_DEPTH = DEF_LOOKAHEAD_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    lzc_in_if.sink             item_in,
    lzc_out_if.source          triple_out
);

    lzc_cfg_t  cfg_reg;
    logic      cfg_we;
    logic      cmd_valid;
    logic      cmd_ready;
    lzc_cmd_t  cmd;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window    <= WINDOW_RESET;
            cfg_reg.max_match <= MAXLEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_WINDOW: cfg_reg.window    <= pwdata[WIN_W-1:0];
                REG_MAXLEN: cfg_reg.max_match <= pwdata[BYTE_W-1:0];
                default:    cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW: prdata = 32'(cfg_reg.window);
            REG_MAXLEN: prdata = 32'(cfg_reg.max_match);
            default:    prdata = '0;
        endcase
    end

    lzc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    lzc_engine
    #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready),
        .triple_out (triple_out)
    );

endmodule

// File: sv/lzc_front.sv
// ----------------------------------------------------------------------------
// lzc_front
// Accepts input beats, decodes the operation and queues commands (2 deep).
// ----------------------------------------------------------------------------
module lzc_front import lzc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lzc_in_if.sink       item_in,
    output logic         cmd_valid,
    output lzc_cmd_t     cmd,
    input  logic         cmd_ready
);

    lzc_cmd_t    q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_wr, do_rd;
    lzc_cmd_t    decoded;

    // decode incoming beat
    always_comb
    begin
        decoded.op   = lzc_op_e'(item_in.operation);
        decoded.data = item_in.data_byte;
    end

    assign item_in.ready = (cnt_reg != 2'd2);
    assign do_wr         = item_in.valid && item_in.ready;
    assign cmd_valid     = (cnt_reg != 2'd0);
    assign do_rd         = cmd_valid && cmd_ready;
    assign cmd           = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue entries, payload only
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// File: sv/lzc_engine.sv
// ----------------------------------------------------------------------------
// lzc_engine
// Lookahead buffer, history memory and the sequential greedy match search.
// ----------------------------------------------------------------------------
module lzc_engine import lzc_pkg::*;
#(
    parameter int HISTORY_DEPTH   = DEF_HISTORY_DEPTH,
    parameter int LOOKAHEAD_DEPTH = DEF_LOOKAHEAD_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  lzc_cfg_t     cfg,
    input  logic         cmd_valid,
    input  lzc_cmd_t     cmd,
    output logic         cmd_ready,
    lzc_out_if.source    triple_out
);

    localparam int HA = $clog2(HISTORY_DEPTH);
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int DW = (HW > WIN_W) ? HW : WIN_W;
    localparam int LW = $clog2(LOOKAHEAD_DEPTH);
    localparam int CW = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int SW = ((LW > BYTE_W) ? LW : BYTE_W) + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHECK  = 10'b0000000010,
        S_SETUP  = 10'b0000000100,
        S_RD     = 10'b0000001000,
        S_CMP    = 10'b0000010000,
        S_LIT_RD = 10'b0000100000,
        S_LIT    = 10'b0001000000,
        S_CP_RD  = 10'b0010000000,
        S_CP_WR  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [HA-1:0]       ptr_reg, ptr_next;
    logic [HW-1:0]       fill_reg, fill_next;
    logic [DW-1:0]       d_reg, d_next;
    logic [BYTE_W-1:0]   k_reg, k_next;
    logic [BYTE_W-1:0]   limit_reg, limit_next;
    logic [BYTE_W-1:0]   match_len_reg, match_len_next;
    logic [WIN_W-1:0]    match_off_reg, match_off_next;
    logic [BYTE_W-1:0]   t_reg, t_next;
    logic                drain_reg, drain_next;
    logic                last_reg, last_next;
    logic [BYTE_W-1:0]   lit_reg, lit_next;

    logic                ov_reg, ov_next;
    logic [WIN_W-1:0]    o_off_reg;
    logic [BYTE_W-1:0]   o_len_reg;
    logic [BYTE_W-1:0]   o_lit_reg;
    logic                o_last_reg;
    logic                o_load;

    logic [BYTE_W-1:0]   la_mem [LOOKAHEAD_DEPTH];
    logic [BYTE_W-1:0]   hist_mem [HISTORY_DEPTH];
    logic [BYTE_W-1:0]   la_q, hist_q;
    logic [LW-1:0]       la_raddr, la_waddr;
    logic                la_we;
    logic [HA-1:0]       hist_raddr;
    logic                hist_we;

    logic [9:0]          thr, cnt_ext, cm1;
    logic [DW-1:0]       span;
    logic [DW:0]         xdist, pext, hsum;
    logic [BYTE_W-1:0]   k_inc, k_end, best_new;
    logic [BYTE_W-1:0]   la_off;
    logic                inner_more, outer_more;
    logic [CW-1:0]       remain;

    // modular add into the lookahead ring
    function automatic logic [LW-1:0] la_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] lim;
        lim = SW'(LOOKAHEAD_DEPTH);
        if (s >= lim)
            return LW'(s - lim);
        else
            return LW'(s);
    endfunction

    // next history slot
    function automatic logic [HA-1:0] ptr_inc(input logic [HA-1:0] p);
        if (p == HA'(HISTORY_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    // lookahead read address: match byte, literal or copy byte
    always_comb
    begin
        la_off = k_reg;
        if (state_reg == S_LIT_RD)
            la_off = match_len_reg;
        else if (state_reg == S_CP_RD)
            la_off = t_reg;
        la_raddr = la_wrap(SW'(head_reg) + SW'(la_off));
        la_waddr = la_wrap(SW'(head_reg) + SW'(count_reg));
    end

    // history read address: ptr - (d - k), wrapped
    always_comb
    begin
        xdist = (DW + 1)'(d_reg) - (DW + 1)'(k_reg);
        pext  = (DW + 1)'(ptr_reg);
        if (pext >= xdist)
            hsum = pext - xdist;
        else
            hsum = pext + (DW + 1)'(HISTORY_DEPTH) - xdist;
        hist_raddr = HA'(hsum);
    end

    assign la_we   = (state_reg == S_IDLE) && cmd_valid && (cmd.op == OP_PUSH)
                     && (count_reg < CW'(LOOKAHEAD_DEPTH));
    assign hist_we = (state_reg == S_CP_WR);

    always_ff @(posedge clk)
    begin
        if (la_we)
            la_mem[la_waddr] <= cmd.data;
        la_q <= la_mem[la_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[ptr_reg] <= la_q;
        hist_q <= hist_mem[hist_raddr];
    end

    // search helpers
    always_comb
    begin
        cnt_ext = 10'(count_reg);
        thr     = 10'(cfg.max_match) + 10'd1;
        if (thr > 10'(LOOKAHEAD_DEPTH))
            thr = 10'(LOOKAHEAD_DEPTH);
        cm1  = cnt_ext - 10'd1;
        span = (DW'(cfg.window) < DW'(fill_reg)) ? DW'(cfg.window) : DW'(fill_reg);
        k_inc      = k_reg + 1'b1;
        inner_more = (hist_q == la_q) && (k_inc < limit_reg)
                     && (DW'(k_inc) < d_reg);
        k_end      = (hist_q == la_q) ? k_inc : k_reg;
        best_new   = (k_end > match_len_reg) ? k_end : match_len_reg;
        outer_more = (d_reg > DW'(1)) && (best_new < limit_reg);
        remain     = count_reg - CW'(match_len_reg) - 1'b1;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign o_load    = (state_reg == S_OUT) && (!ov_reg || triple_out.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        limit_next     = limit_reg;
        match_len_next = match_len_reg;
        match_off_next = match_off_reg;
        t_next         = t_reg;
        drain_next     = drain_reg;
        last_next      = last_reg;
        lit_next       = lit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_PUSH)
                    begin
                        if (la_we)
                            count_next = count_reg + 1'b1;
                        drain_next = 1'b0;
                        state_next = S_CHECK;
                    end
                    else if (count_reg == '0)
                    begin
                        fill_next = '0;
                        ptr_next  = '0;
                    end
                    else
                    begin
                        drain_next = 1'b1;
                        state_next = S_SETUP;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = (cnt_ext >= thr) ? S_SETUP : S_IDLE;
            end
            S_SETUP:
            begin
                limit_next     = (10'(cfg.max_match) < cm1) ? cfg.max_match : cm1[7:0];
                match_len_next = '0;
                match_off_next = '0;
                d_next         = span;
                k_next         = '0;
                if ((span == '0) || (limit_next == '0))
                    state_next = S_LIT_RD;
                else
                    state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (inner_more)
                begin
                    k_next     = k_inc;
                    state_next = S_RD;
                end
                else
                begin
                    if (k_end > match_len_reg)
                    begin
                        match_len_next = k_end;
                        match_off_next = d_reg[WIN_W-1:0];
                    end
                    d_next     = d_reg - 1'b1;
                    k_next     = '0;
                    state_next = outer_more ? S_RD : S_LIT_RD;
                end
            end
            S_LIT_RD:
            begin
                state_next = S_LIT;
            end
            S_LIT:
            begin
                lit_next   = la_q;
                t_next     = '0;
                state_next = S_CP_RD;
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                ptr_next = ptr_inc(ptr_reg);
                if (fill_reg < HW'(HISTORY_DEPTH))
                    fill_next = fill_reg + 1'b1;
                t_next = t_reg + 1'b1;
                if (t_reg == match_len_reg)
                begin
                    head_next  = la_wrap(SW'(head_reg) + SW'(match_len_reg) + SW'(1));
                    count_next = remain;
                    last_next  = drain_reg && (remain == '0);
                    if (drain_reg && (remain == '0))
                    begin
                        fill_next = '0;
                        ptr_next  = '0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CP_RD;
                end
            end
            S_OUT:
            begin
                if (o_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output slot valid
    always_comb
    begin
        ov_next = ov_reg;
        if (triple_out.ready)
            ov_next = 1'b0;
        if (o_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            fill_reg  <= '0;
            drain_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            ov_reg    <= ov_next;
        end
    end

    // search datapath and output payload
    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        k_reg         <= k_next;
        limit_reg     <= limit_next;
        match_len_reg <= match_len_next;
        match_off_reg <= match_off_next;
        t_reg         <= t_next;
        last_reg      <= last_next;
        lit_reg       <= lit_next;
        if (o_load)
        begin
            o_off_reg  <= match_off_reg;
            o_len_reg  <= match_len_reg;
            o_lit_reg  <= lit_reg;
            o_last_reg <= last_reg;
        end
    end

    assign triple_out.valid        = ov_reg;
    assign triple_out.match_offset = o_off_reg;
    assign triple_out.match_length = o_len_reg;
    assign triple_out.literal      = o_lit_reg;
    assign triple_out.last         = o_last_reg;

endmodule
